### rtl/core/aprs_pkg.sv
// ----------------------------------------------------------------------------
// aprs_pkg: shared definitions for the AABB penetration resolver
// Item kinds, push axis codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package aprs_pkg;

	// default coordinate width (signed Q23.8 at 32 bits)
	localparam int DEF_COORD_WIDTH = 32;

	// register file: index field width
	localparam int REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	// register reset values, Q23.8 (25.0 and 87.5)
	localparam int BOX_MIN_X_RST = -6400;
	localparam int BOX_MIN_Y_RST = -6400;
	localparam int BOX_MIN_Z_RST = -22400;
	localparam int BOX_MAX_X_RST = 6400;
	localparam int BOX_MAX_Y_RST = 6400;
	localparam int BOX_MAX_Z_RST = 22400;

	// input item kinds
	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_OBSTACLE = 1'b1;

	// push axis codes
	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_X    = 2'd1;
	localparam logic [1:0] AXIS_Y    = 2'd2;
	localparam logic [1:0] AXIS_Z    = 2'd3;

endpackage

### rtl/core/aprs_regs.sv
// ----------------------------------------------------------------------------
// aprs_regs: APB register file for the player box corner offsets
// Six signed offsets, written in the APB access phase (psel and penable), always ready.
// ----------------------------------------------------------------------------
module aprs_regs
	import aprs_pkg::*;
#(
	parameter int W = DEF_COORD_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [(W > 32 ? 6 : 5)-1:0] paddr,
	input  logic [(W > 32 ? 64 : 32)-1:0] pwdata,
	output logic [(W > 32 ? 64 : 32)-1:0] prdata,
	output logic                     pready,
	output logic signed [W-1:0]      box_min_x,
	output logic signed [W-1:0]      box_min_y,
	output logic signed [W-1:0]      box_min_z,
	output logic signed [W-1:0]      box_max_x,
	output logic signed [W-1:0]      box_max_y,
	output logic signed [W-1:0]      box_max_z
);

	localparam int ADDR_SHIFT = (W > 32) ? 3 : 2;
	localparam int ADDR_W     = ADDR_SHIFT + REG_IDX_W;
	localparam int DATA_W     = (W > 32) ? 64 : 32;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	logic signed [W-1:0]  wval;
	logic signed [W-1:0]  box_min_x_q, box_min_y_q, box_min_z_q;
	logic signed [W-1:0]  box_max_x_q, box_max_y_q, box_max_z_q;

	assign idx    = paddr[ADDR_W-1:ADDR_SHIFT];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wval   = pwdata[W-1:0];

	// register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= W'(BOX_MIN_X_RST);
			box_min_y_q <= W'(BOX_MIN_Y_RST);
			box_min_z_q <= W'(BOX_MIN_Z_RST);
			box_max_x_q <= W'(BOX_MAX_X_RST);
			box_max_y_q <= W'(BOX_MAX_Y_RST);
			box_max_z_q <= W'(BOX_MAX_Z_RST);
		end else if (wr_en) begin
			case (idx)
				REG_BOX_MIN_X: box_min_x_q <= wval;
				REG_BOX_MIN_Y: box_min_y_q <= wval;
				REG_BOX_MIN_Z: box_min_z_q <= wval;
				REG_BOX_MAX_X: box_max_x_q <= wval;
				REG_BOX_MAX_Y: box_max_y_q <= wval;
				REG_BOX_MAX_Z: box_max_z_q <= wval;
				default: ;
			endcase
		end
	end

	// read mux, sign-extended to the bus width
	always_comb begin
		case (idx)
			REG_BOX_MIN_X: prdata = DATA_W'(box_min_x_q);
			REG_BOX_MIN_Y: prdata = DATA_W'(box_min_y_q);
			REG_BOX_MIN_Z: prdata = DATA_W'(box_min_z_q);
			REG_BOX_MAX_X: prdata = DATA_W'(box_max_x_q);
			REG_BOX_MAX_Y: prdata = DATA_W'(box_max_y_q);
			REG_BOX_MAX_Z: prdata = DATA_W'(box_max_z_q);
			default:       prdata = '0;
		endcase
	end

	assign box_min_x = box_min_x_q;
	assign box_min_y = box_min_y_q;
	assign box_min_z = box_min_z_q;
	assign box_max_x = box_max_x_q;
	assign box_max_y = box_max_y_q;
	assign box_max_z = box_max_z_q;

endmodule

### rtl/core/aprs_axis.sv
// ----------------------------------------------------------------------------
// aprs_axis: one-axis overlap test and push candidate
// Builds the player extent on one axis, tests separation, picks the smaller
// push and precomputes the pushed coordinate. All adds saturate.
// ----------------------------------------------------------------------------
module aprs_axis
	import aprs_pkg::*;
#(
	parameter int W = DEF_COORD_WIDTH
) (
	input  logic signed [W-1:0] cur,
	input  logic signed [W-1:0] box_min,
	input  logic signed [W-1:0] box_max,
	input  logic signed [W-1:0] obs_min,
	input  logic signed [W-1:0] obs_max,
	output logic                apart,
	output logic        [W-1:0] push_mag,
	output logic signed [W-1:0] pushed
);

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? SMIN : SMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? SMIN : SMAX;
		return s[W-1:0];
	endfunction

	// exact magnitude; the most negative value maps to 2^(W-1)
	function automatic logic [W-1:0] magn(input logic signed [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	logic signed [W-1:0] pmin, pmax;
	logic signed [W-1:0] d_hi, d_lo, d;
	logic        [W-1:0] m_hi, m_lo;

	// player extent and separation test (touching counts as overlap)
	assign pmin  = sat_add(cur, box_min);
	assign pmax  = sat_add(cur, box_max);
	assign apart = (pmax < obs_min) || (obs_max < pmin);

	// candidates; ties go to the obstacle-min side
	assign d_hi = sat_sub(obs_max, pmin);
	assign d_lo = sat_sub(obs_min, pmax);
	assign m_hi = magn(d_hi);
	assign m_lo = magn(d_lo);
	assign d    = (m_hi < m_lo) ? d_hi : d_lo;

	assign push_mag = (m_hi < m_lo) ? m_hi : m_lo;
	assign pushed   = sat_add(cur, d);

endmodule

### rtl/core/aabb_penetration_resolver_top.sv
// ----------------------------------------------------------------------------
// aabb_penetration_resolver_top: actor box versus obstacle box resolver
//
// Input channel (in_valid/in_ready): kind 0 loads start_x/y/z as the actor
// position, kind 1 tests one obstacle box against the player box (position
// plus the configured corner offsets) and applies the smallest push on a
// single axis. Every transaction yields one result transaction on the
// output channel (out_valid/out_ready): pos_x/y/z after the item and
// push_axis (0 none, 1 x, 2 y, 3 z).
// An accepted item waits in the input register until the result slot is
// free, then its result enters the result register and raises out_valid.
// The block takes one item per cycle while the receiver keeps out_ready
// high: the whole test, push pick and saturating add run between those
// registers, and the result register doubles as the position state.
// When the receiver stalls, the result holds and the input register still
// takes one more item; in_ready drops only when both are full. Reset
// clears the position to zero, empties both registers and loads the default
// box offsets (+-25.0 in x and y, +-87.5 in z). The user must write box
// offsets over the APB port only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module aabb_penetration_resolver_top
	import aprs_pkg::*;
#(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [(COORD_WIDTH > 32 ? 6 : 5)-1:0]   paddr,
	input  logic [(COORD_WIDTH > 32 ? 64 : 32)-1:0] pwdata,
	output logic [(COORD_WIDTH > 32 ? 64 : 32)-1:0] prdata,
	output logic                           pready,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic signed [COORD_WIDTH-1:0]  start_x,
	input  logic signed [COORD_WIDTH-1:0]  start_y,
	input  logic signed [COORD_WIDTH-1:0]  start_z,
	input  logic signed [COORD_WIDTH-1:0]  obstacle_min_x,
	input  logic signed [COORD_WIDTH-1:0]  obstacle_min_y,
	input  logic signed [COORD_WIDTH-1:0]  obstacle_min_z,
	input  logic signed [COORD_WIDTH-1:0]  obstacle_max_x,
	input  logic signed [COORD_WIDTH-1:0]  obstacle_max_y,
	input  logic signed [COORD_WIDTH-1:0]  obstacle_max_z,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COORD_WIDTH-1:0]  pos_x,
	output logic signed [COORD_WIDTH-1:0]  pos_y,
	output logic signed [COORD_WIDTH-1:0]  pos_z,
	output logic [1:0]                     push_axis
);

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [W-1:0] box_max_x, box_max_y, box_max_z;

	// input register
	logic                v_s1;
	logic                kind_s1;
	logic signed [W-1:0] start_x_s1, start_y_s1, start_z_s1;
	logic signed [W-1:0] omin_x_s1, omin_y_s1, omin_z_s1;
	logic signed [W-1:0] omax_x_s1, omax_y_s1, omax_z_s1;

	// result register, also the actor position state
	logic                out_valid_q;
	logic signed [W-1:0] cur_x_q, cur_y_q, cur_z_q;
	logic [1:0]          push_axis_q;

	logic                in_fire, adv;
	logic                apart_x, apart_y, apart_z;
	logic [W-1:0]        mag_x, mag_y, mag_z;
	logic signed [W-1:0] pushed_x, pushed_y, pushed_z;
	logic [1:0]          axis_next;

	aprs_regs #(.W(W)) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z)
	);

	// handshake: the input register advances whenever the result slot frees
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// input payload capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1    <= kind;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			start_z_s1 <= start_z;
			omin_x_s1  <= obstacle_min_x;
			omin_y_s1  <= obstacle_min_y;
			omin_z_s1  <= obstacle_min_z;
			omax_x_s1  <= obstacle_max_x;
			omax_y_s1  <= obstacle_max_y;
			omax_z_s1  <= obstacle_max_z;
		end
	end

	// per-axis test and candidates
	aprs_axis #(.W(W)) u_axis_x (
		.cur (cur_x_q), .box_min (box_min_x), .box_max (box_max_x),
		.obs_min (omin_x_s1), .obs_max (omax_x_s1),
		.apart (apart_x), .push_mag (mag_x), .pushed (pushed_x)
	);

	aprs_axis #(.W(W)) u_axis_y (
		.cur (cur_y_q), .box_min (box_min_y), .box_max (box_max_y),
		.obs_min (omin_y_s1), .obs_max (omax_y_s1),
		.apart (apart_y), .push_mag (mag_y), .pushed (pushed_y)
	);

	aprs_axis #(.W(W)) u_axis_z (
		.cur (cur_z_q), .box_min (box_min_z), .box_max (box_max_z),
		.obs_min (omin_z_s1), .obs_max (omax_z_s1),
		.apart (apart_z), .push_mag (mag_z), .pushed (pushed_z)
	);

	// smallest push wins, x before y before z on ties
	always_comb begin
		if (kind_s1 == KIND_LOAD || apart_x || apart_y || apart_z)
			axis_next = AXIS_NONE;
		else if (mag_x <= mag_y && mag_x <= mag_z)
			axis_next = AXIS_X;
		else if (mag_y <= mag_x && mag_y <= mag_z)
			axis_next = AXIS_Y;
		else
			axis_next = AXIS_Z;
	end

	// result register and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_z_q     <= '0;
			push_axis_q <= AXIS_NONE;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				push_axis_q <= axis_next;
				if (kind_s1 == KIND_LOAD) begin
					cur_x_q <= start_x_s1;
					cur_y_q <= start_y_s1;
					cur_z_q <= start_z_s1;
				end else begin
					case (axis_next)
						AXIS_X:  cur_x_q <= pushed_x;
						AXIS_Y:  cur_y_q <= pushed_y;
						AXIS_Z:  cur_z_q <= pushed_z;
						default: ;
					endcase
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = cur_x_q;
	assign pos_y     = cur_y_q;
	assign pos_z     = cur_z_q;
	assign push_axis = push_axis_q;

	// a load never reports a push
	a_load_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == KIND_LOAD) |=> (push_axis == AXIS_NONE))
		else $error("load transaction reported a push");

	// a load takes the start position as given
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == KIND_LOAD) |=>
		(pos_x == $past(start_x_s1) && pos_y == $past(start_y_s1) &&
		 pos_z == $past(start_z_s1)))
		else $error("load transaction position mismatch");

	// no overlap leaves the position alone
	a_no_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == KIND_OBSTACLE && axis_next == AXIS_NONE) |=>
		($stable(cur_x_q) && $stable(cur_y_q) && $stable(cur_z_q)))
		else $error("position moved without a push");

	// an obstacle moves at most one coordinate
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == KIND_OBSTACLE) |=>
		($countones({cur_x_q != $past(cur_x_q), cur_y_q != $past(cur_y_q),
			cur_z_q != $past(cur_z_q)}) <= 1))
		else $error("obstacle pushed more than one axis");

	// state only changes when an item moves into the result slot
	a_state_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(cur_x_q) && $stable(cur_y_q) && $stable(cur_z_q)))
		else $error("position changed without a transaction");

endmodule
